// ----- rtl/windowed_clocked_kernel_convolver_core_assert.svh -----
// Assertion macros for the windowed kernel convolver checker.
// Depends on nothing; taken in by the checker file.
`ifndef WINDOWED_CLOCKED_KERNEL_CONVOLVER_CORE_ASSERT_SVH
`define WINDOWED_CLOCKED_KERNEL_CONVOLVER_CORE_ASSERT_SVH

// Same-cycle implication, idle during reset
`define WCKC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wckc assertion failed");

// Next-cycle implication, idle during reset
`define WCKC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wckc assertion failed");

`endif

// ----- rtl/wckc_pkg.sv -----
// Shared constants and types for the windowed kernel convolver.
// Used by the channel interfaces, the core and the checker.
package wckc_pkg;

    localparam int TAPS_DEF        = 128;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int OUT_W           = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    // quotient bits of the weight divider
    localparam int QBITS           = 16;
    // floor(0.9 * 2^28)
    localparam logic [27:0] WEIGHT_NUM = 28'd241591910;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_ENABLE     = 3'd0,
        CFG_PHASE_STEP     = 3'd1,
        CFG_KERNEL_GAIN    = 3'd2,
        CFG_WINDOW_ROLLOFF = 3'd3,
        CFG_WINDOW_LENGTH  = 3'd4,
        CFG_TRIGGER_HIGH   = 3'd5,
        CFG_TRIGGER_LOW    = 3'd6
    } cfg_idx_t;

endpackage

// ----- rtl/wckc_stream_if.sv -----
// Valid/ready channels for input items and result items.
// Depends on wckc_pkg.
interface wckc_in_if
    import wckc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] signal_sample;
    logic                          signal_present;
    logic signed [SAMPLE_BITS-1:0] kernel_sample;
    logic signed [15:0]            clock_level;
    logic                          clock_present;

    modport source (output valid, signal_sample, signal_present, kernel_sample,
                    clock_level, clock_present, input ready);
    modport sink   (input valid, signal_sample, signal_present, kernel_sample,
                    clock_level, clock_present, output ready);
endinterface

interface wckc_out_if
    import wckc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] conv_out;

    modport source (output valid, conv_out, input ready);
    modport sink   (input valid, conv_out, output ready);
endinterface

// ----- rtl/windowed_clocked_kernel_convolver_core.sv -----
// An input item is accepted only while the core is idle, and the core does not take the next
// item until it has worked through every tap and written the result: one tap is read per cycle
// from the single read port of each delay-line memory, and each tap's window weight passes a
// 16-stage restoring divider before two multiply stages and the accumulator. Input ready is
// high only while the core is idle; a finished result waits in the output register. Both delay
// lines read as zero until written, tracked by fill counts, so no clearing pass follows reset.
// Depends on wckc_pkg and wckc_stream_if.
module windowed_clocked_kernel_convolver_core
    import wckc_pkg::*;
#(
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    wckc_in_if.sink               samples,
    wckc_out_if.source            results
);

    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW   = $clog2(TAPS + 1);
    localparam int MW   = 16 + AW;
    localparam int DENW = MW + 1;
    localparam int NW   = ((MW > 28) ? MW : 28) + 1;
    localparam int TW   = ((DENW + QBITS > NW) ? DENW + QBITS : NW);
    localparam int WPW  = QBITS + 1 + SB;
    localparam int PW   = WPW + SB;
    localparam int ACCW = PW + AW + 1;
    localparam int RW   = ((ACCW > OUT_W) ? ACCW : OUT_W) + 1;
    localparam int KW   = SB + 18;

    localparam logic [AW-1:0]         LAST_TAP = AW'(TAPS - 1);
    localparam logic signed [KW-1:0]  KMAX = KW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [KW-1:0]  KMIN = -KMAX - KW'(1);
    localparam logic signed [RW-1:0]  RMAX = RW'(64'sd2147483647);
    localparam logic signed [RW-1:0]  RMIN = -RMAX - RW'(1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RUN    = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic                 v;
        logic                 last;
        logic signed [SB-1:0] s;
        logic signed [SB-1:0] k;
        logic [DENW-1:0]      den;
        logic [NW-1:0]        rem;
        logic [QBITS-1:0]     q;
    } dstage_t;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        return (a == LAST_TAP) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_TAP : a - 1'b1;
    endfunction

    // configuration
    logic                run_reg;
    logic [31:0]         step_reg;
    logic [15:0]         gain_reg;
    logic [15:0]         roll_reg;
    logic [15:0]         len_reg;
    logic signed [15:0]  thi_reg;
    logic signed [15:0]  tlo_reg;

    // delay-line memories
    logic signed [SB-1:0] sig_mem [TAPS];
    logic signed [SB-1:0] ker_mem [TAPS];
    logic signed [SB-1:0] sig_rd_reg;
    logic signed [SB-1:0] ker_rd_reg;

    state_t              state_reg;
    logic [AW-1:0]       sig_head_reg, ker_head_reg;
    logic [CW-1:0]       sig_fill_reg, ker_fill_reg;
    logic [AW-1:0]       sig_ra_reg, ker_ra_reg;
    logic [31:0]         phase_reg;
    logic                trig_reg;
    logic [AW-1:0]       cnt_reg;

    logic                s1_v_reg, s1_last_reg, s1_sv_reg, s1_kv_reg;
    logic [MW-1:0]       s1_prod_reg;
    dstage_t             dv_reg  [QBITS+1];
    dstage_t             dv_next [QBITS+1];

    logic                m1_v_reg, m1_last_reg;
    logic signed [SB-1:0]  m1_k_reg;
    logic signed [WPW-1:0] wp_reg;
    logic                m2_v_reg, m2_last_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [ACCW-1:0] acc_reg;

    logic                   out_valid_reg;
    logic signed [OUT_W-1:0] out_data_reg;

    logic                   in_acc;
    logic                   iss_v;
    logic signed [SB-1:0]   sig_wr;
    logic [32:0]            phase_sum;
    logic                   trig_next;
    logic                   tick;
    logic signed [SB+16:0]  ker_prod;
    logic signed [KW-1:0]   ker_sum;
    logic signed [KW-1:0]   ker_sh;
    logic signed [SB-1:0]   ker_wr;
    logic [MW-1:0]          len_term;
    logic [MW-1:0]          mag;
    logic [DENW-1:0]        den;
    logic signed [RW-1:0]   rsum;
    logic signed [RW-1:0]   rsh;
    logic signed [OUT_W-1:0] res;

    assign samples.ready    = (state_reg == S_IDLE);
    assign in_acc           = samples.valid && samples.ready;
    assign results.valid    = out_valid_reg;
    assign results.conv_out = out_data_reg;
    assign iss_v            = (state_reg == S_RUN);

    // take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
            gain_reg <= 16'd4096;
            roll_reg <= '0;
            len_reg  <= '0;
            thi_reg  <= 16'sd1024;
            tlo_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RUN_ENABLE:     run_reg  <= cfg_data[0];
                CFG_PHASE_STEP:     step_reg <= cfg_data[31:0];
                CFG_KERNEL_GAIN:    gain_reg <= cfg_data[15:0];
                CFG_WINDOW_ROLLOFF: roll_reg <= cfg_data[15:0];
                CFG_WINDOW_LENGTH:  len_reg  <= cfg_data[15:0];
                CFG_TRIGGER_HIGH:   thi_reg  <= cfg_data[15:0];
                CFG_TRIGGER_LOW:    tlo_reg  <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    // signal value, phase carry and Schmitt trigger for the item at the port
    always_comb
    begin
        sig_wr    = samples.signal_present ? samples.signal_sample : '0;
        phase_sum = {1'b0, phase_reg} + {1'b0, step_reg};
        trig_next = trig_reg;
        tick      = 1'b0;
        if (samples.clock_present)
        begin
            if (trig_reg)
            begin
                if (samples.clock_level <= tlo_reg)
                    trig_next = 1'b0;
            end
            else if (samples.clock_level >= thi_reg)
            begin
                trig_next = 1'b1;
                tick      = 1'b1;
            end
        end
        else
        begin
            tick = phase_sum[32];
        end
    end

    // scale the kernel sample, round half up and saturate
    always_comb
    begin
        ker_prod = samples.kernel_sample * $signed({1'b0, gain_reg});
        ker_sum  = KW'(ker_prod) + KW'(2048);
        ker_sh   = ker_sum >>> 12;
        if (ker_sh > KMAX)
            ker_wr = KMAX[SB-1:0];
        else if (ker_sh < KMIN)
            ker_wr = KMIN[SB-1:0];
        else
            ker_wr = ker_sh[SB-1:0];
    end

    // delay lines: write on acceptance (kernel on a running tick), read one tap a cycle
    always_ff @(posedge clk)
    begin
        if (in_acc)
            sig_mem[sig_head_reg] <= sig_wr;
        if (in_acc && run_reg && tick)
            ker_mem[ker_head_reg] <= ker_wr;
        sig_rd_reg <= sig_mem[sig_ra_reg];
        ker_rd_reg <= ker_mem[ker_ra_reg];
    end

    // window distance and weight divider operands
    always_comb
    begin
        len_term = MW'(TAPS) * MW'(len_reg);
        if (s1_prod_reg >= len_term)
            mag = s1_prod_reg - len_term;
        else
            mag = len_term - s1_prod_reg;
        den = {1'b0, mag} + DENW'(4096);

        dv_next[0].v    = s1_v_reg;
        dv_next[0].last = s1_last_reg;
        dv_next[0].s    = s1_sv_reg ? sig_rd_reg : '0;
        dv_next[0].k    = s1_kv_reg ? ker_rd_reg : '0;
        dv_next[0].den  = den;
        dv_next[0].rem  = NW'(WEIGHT_NUM) + NW'(den >> 1);
        dv_next[0].q    = '0;

        // one quotient bit per stage, most significant first
        for (int i = 1; i <= QBITS; i++)
        begin
            dv_next[i] = dv_reg[i-1];
            if (TW'(dv_reg[i-1].rem) >= (TW'(dv_reg[i-1].den) << (QBITS - i)))
            begin
                dv_next[i].rem = NW'(TW'(dv_reg[i-1].rem)
                                 - (TW'(dv_reg[i-1].den) << (QBITS - i)));
                dv_next[i].q[QBITS-i] = 1'b1;
            end
        end
    end

    // round the sum half up to Q12.20 and saturate
    always_comb
    begin
        rsum = RW'(acc_reg) + RW'(33554432);
        rsh  = rsum >>> 26;
        if (rsh > RMAX)
            res = RMAX[OUT_W-1:0];
        else if (rsh < RMIN)
            res = RMIN[OUT_W-1:0];
        else
            res = rsh[OUT_W-1:0];
    end

    // sequencer, pipeline and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sig_head_reg  <= '0;
            ker_head_reg  <= '0;
            sig_fill_reg  <= '0;
            ker_fill_reg  <= '0;
            sig_ra_reg    <= '0;
            ker_ra_reg    <= '0;
            phase_reg     <= '0;
            trig_reg      <= 1'b0;
            cnt_reg       <= '0;
            s1_v_reg      <= 1'b0;
            s1_last_reg   <= 1'b0;
            s1_sv_reg     <= 1'b0;
            s1_kv_reg     <= 1'b0;
            s1_prod_reg   <= '0;
            for (int i = 0; i <= QBITS; i++)
                dv_reg[i] <= '0;
            m1_v_reg      <= 1'b0;
            m1_last_reg   <= 1'b0;
            m1_k_reg      <= '0;
            wp_reg        <= '0;
            m2_v_reg      <= 1'b0;
            m2_last_reg   <= 1'b0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // tap issue stage
            s1_v_reg    <= iss_v;
            s1_last_reg <= iss_v && (cnt_reg == LAST_TAP);
            s1_sv_reg   <= CW'(cnt_reg) < sig_fill_reg;
            s1_kv_reg   <= CW'(cnt_reg) < ker_fill_reg;
            s1_prod_reg <= MW'(cnt_reg) * MW'(roll_reg);

            // divider stages
            for (int i = 0; i <= QBITS; i++)
                dv_reg[i] <= dv_next[i];

            // weight times signal, then times kernel
            m1_v_reg    <= dv_reg[QBITS].v;
            m1_last_reg <= dv_reg[QBITS].last;
            m1_k_reg    <= dv_reg[QBITS].k;
            wp_reg      <= $signed({1'b0, dv_reg[QBITS].q}) * dv_reg[QBITS].s;
            m2_v_reg    <= m1_v_reg;
            m2_last_reg <= m1_last_reg;
            prod_reg    <= wp_reg * m1_k_reg;

            if (m2_v_reg)
                acc_reg <= acc_reg + ACCW'(prod_reg);

            // drop the result once taken
            if (out_valid_reg && results.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        sig_head_reg <= ptr_inc(sig_head_reg);
                        if (sig_fill_reg != CW'(TAPS))
                            sig_fill_reg <= sig_fill_reg + 1'b1;
                        sig_ra_reg <= sig_head_reg;
                        ker_ra_reg <= ptr_dec(ker_head_reg);
                        if (run_reg)
                        begin
                            phase_reg <= phase_sum[31:0];
                            trig_reg  <= trig_next;
                            if (tick)
                            begin
                                ker_head_reg <= ptr_inc(ker_head_reg);
                                if (ker_fill_reg != CW'(TAPS))
                                    ker_fill_reg <= ker_fill_reg + 1'b1;
                                ker_ra_reg <= ker_head_reg;
                            end
                        end
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    // advance to the next older tap
                    cnt_reg    <= cnt_reg + 1'b1;
                    sig_ra_reg <= ptr_dec(sig_ra_reg);
                    ker_ra_reg <= ptr_dec(ker_ra_reg);
                    if (cnt_reg == LAST_TAP)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (m2_v_reg && m2_last_reg)
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || results.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/wckc_checker.sv -----
// Port-level checker for the windowed kernel convolver, with its bind.
// Depends on wckc_pkg and the assertion macro header.
`include "windowed_clocked_kernel_convolver_core_assert.svh"

module wckc_checker
    import wckc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] out_data
);

    // one item at a time: ready drops after each accepted item
    `WCKC_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    // a new result appears only as the core returns to idle
    `WCKC_ASSERT_IMP(a_result_at_end, clk, rst_n, $rose(out_valid), $past(!in_ready) && in_ready)

    // a stalled result holds
    `WCKC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(out_data))

endmodule

bind windowed_clocked_kernel_convolver_core wckc_checker u_wckc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.conv_out)
);
